FILE: rtl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Widths, types and cofactor index tables shared by the 3x3 inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

	localparam int ELEM_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int NELEM      = 9;

	localparam int PW   = 2 * ELEM_WIDTH;                 // pair product
	localparam int CW   = PW + 1;                         // signed cofactor
	localparam int DW   = 3 * ELEM_WIDTH + 3;             // signed determinant
	localparam int CMW  = PW;                             // cofactor magnitude
	localparam int DMW  = 3 * ELEM_WIDTH;                 // determinant magnitude
	localparam int NW   = 3 * ELEM_WIDTH + 2 * FRAC_BITS + 2; // rounded numerator
	localparam int DNW  = DMW + 1;                        // doubled divisor
	localparam int RW   = DMW + 2;                        // partial remainder
	localparam int DATA_W      = ((NELEM * ELEM_WIDTH + 7) / 8) * 8;
	localparam int USER_W      = 2;
	localparam int LANE_STAGES = ELEM_WIDTH + 2;
	localparam int FRONT_STAGES = 5;
	localparam int NSTAGES     = FRONT_STAGES + LANE_STAGES + 1;

	localparam int USER_SINGULAR  = 0;
	localparam int USER_SATURATED = 1;

	// cofactor i = p*q - r*s, negated where flip is set (already transposed)
	localparam int COF_P [NELEM] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
	localparam int COF_Q [NELEM] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
	localparam int COF_R [NELEM] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
	localparam int COF_S [NELEM] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
	localparam bit COF_FLIP [NELEM] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

	typedef logic signed [ELEM_WIDTH-1:0] elem_t;
	typedef logic [CMW-1:0] cmag_t;
	typedef logic [DMW-1:0] dmag_t;

	typedef struct packed {
		logic  neg;
		cmag_t cmag;
	} lane_in_t;

	typedef struct packed {
		logic  clip;
		elem_t elem;
	} lane_res_t;

endpackage

FILE: rtl/m3i_div_lane.sv
// ----------------------------------------------------------------------------
// m3i_div_lane
// One element lane: rounded restoring division of |C| * 2^(2F) by |D|,
// one quotient bit per stage, then sign and saturation.
// ----------------------------------------------------------------------------
module m3i_div_lane (
	input  logic                               clk,
	input  logic [m3i_pkg::LANE_STAGES-1:0]    en,
	input  m3i_pkg::lane_in_t                  din,
	input  m3i_pkg::dmag_t                     dmag,
	output m3i_pkg::lane_res_t                 res
);
	localparam int E   = m3i_pkg::ELEM_WIDTH;
	localparam int F   = m3i_pkg::FRAC_BITS;
	localparam int NW  = m3i_pkg::NW;
	localparam int DNW = m3i_pkg::DNW;
	localparam int RW  = m3i_pkg::RW;

	logic [NW-1:0]  num;
	logic [DNW-1:0] den;
	logic           ovf;

	logic [RW-1:0]  rem_s [E+1];
	logic [DNW-1:0] den_s [E+1];
	logic [E-1:0]   low_s [E+1];
	logic [E-1:0]   quo_s [E+1];
	logic           ovf_s [E+1];
	logic           neg_s [E+1];

	always_comb begin
		// (2|C| * 2^(2F) + |D|) / (2|D|) rounds half away from zero
		num = (NW'(din.cmag) << (2 * F + 1)) + NW'(dmag);
		den = {dmag, 1'b0};
		ovf = (num >> E) >= NW'(den);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0] <= RW'(num >> E);
			den_s[0] <= den;
			low_s[0] <= num[E-1:0];
			quo_s[0] <= '0;
			ovf_s[0] <= ovf;
			neg_s[0] <= din.neg;
		end
	end

	for (genvar k = 1; k <= E; k++) begin : g_step
		logic [RW-1:0] trial;
		logic          ge;
		always_comb begin
			trial = {rem_s[k-1][RW-2:0], low_s[k-1][E-k]};
			ge    = trial >= RW'(den_s[k-1]);
		end
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= ge ? trial - RW'(den_s[k-1]) : trial;
				den_s[k] <= den_s[k-1];
				low_s[k] <= low_s[k-1];
				quo_s[k] <= {quo_s[k-1][E-2:0], ge};
				ovf_s[k] <= ovf_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	logic [E-1:0] lim;
	logic [E-1:0] elem_d;
	logic         clip_d;

	always_comb begin
		lim    = {1'b1, {(E-1){1'b0}}};
		clip_d = 1'b0;
		elem_d = quo_s[E];
		if (neg_s[E]) begin
			if (ovf_s[E] || quo_s[E] > lim) begin
				clip_d = 1'b1;
				elem_d = lim;
			end else begin
				elem_d = -quo_s[E];
			end
		end else if (ovf_s[E] || quo_s[E] >= lim) begin
			clip_d = 1'b1;
			elem_d = ~lim;
		end
	end

	always_ff @(posedge clk) begin
		if (en[E+1]) begin
			res.elem <= elem_d;
			res.clip <= clip_d;
		end
	end

endmodule

FILE: rtl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Inverse of a signed Q16.16 3x3 matrix by the adjugate, nine division lanes.
// ----------------------------------------------------------------------------
// Input beat on s_*: tdata carries a00..a22 row-major, 32 bits each, a00 lowest.
// Output beat on m_*: tdata carries b00..b22 in the same order; tuser bit 0 is
// singular (determinant zero, all elements zero), bit 1 is saturated (some
// element clipped to the Q16.16 range).
// From input beat to output beat the stages are: pair products, cofactors,
// determinant partial products, determinant sum, magnitudes, then in each of the
// nine lanes a setup stage, 32 restoring-division stages (one quotient bit each)
// and a saturation stage, then the merging output register.
// One matrix per cycle unless stalled; every stage is a full pipeline register.
// When the receiver holds m_tready low, the output beat holds and stages behind
// it keep filling empty slots, so s_tready falls only once the pipeline is full.
// Reset empties the pipeline; no output beat appears until one has entered.
// ----------------------------------------------------------------------------
module matrix3x3_inverse (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [m3i_pkg::DATA_W-1:0]     s_tdata,  // a00,a01,a02,a10,..,a22
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [m3i_pkg::DATA_W-1:0]     m_tdata,  // b00,b01,b02,b10,..,b22
	output logic [m3i_pkg::USER_W-1:0]     m_tuser   // singular, saturated
);
	localparam int E  = m3i_pkg::ELEM_WIDTH;
	localparam int N  = m3i_pkg::NELEM;
	localparam int NS = m3i_pkg::NSTAGES;
	localparam int FS = m3i_pkg::FRONT_STAGES;
	localparam int LS = m3i_pkg::LANE_STAGES;
	localparam int PW = m3i_pkg::PW;
	localparam int CW = m3i_pkg::CW;
	localparam int DW = m3i_pkg::DW;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	// stage enable: load when empty or when the next stage moves on
	always_comb begin
		en[NS-1] = !vld_q[NS-1] || m_tready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = en[0];

	m3i_pkg::elem_t a [N];
	always_comb begin
		for (int i = 0; i < N; i++) begin
			a[i] = s_tdata[i*E +: E];
		end
	end

	// s1: pair products
	logic signed [PW-1:0] pq_s1 [N];
	logic signed [PW-1:0] rs_s1 [N];
	m3i_pkg::elem_t        row_s1 [3];
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < N; i++) begin
				pq_s1[i] <= a[m3i_pkg::COF_P[i]] * a[m3i_pkg::COF_Q[i]];
				rs_s1[i] <= a[m3i_pkg::COF_R[i]] * a[m3i_pkg::COF_S[i]];
			end
			for (int j = 0; j < 3; j++) begin
				row_s1[j] <= a[j];
			end
		end
	end

	// s2: cofactors
	logic signed [CW-1:0] cof_s2 [N];
	m3i_pkg::elem_t        row_s2 [3];
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < N; i++) begin
				if (m3i_pkg::COF_FLIP[i]) begin
					cof_s2[i] <= CW'(rs_s1[i]) - CW'(pq_s1[i]);
				end else begin
					cof_s2[i] <= CW'(pq_s1[i]) - CW'(rs_s1[i]);
				end
			end
			row_s2 <= row_s1;
		end
	end

	// s3: determinant by the first row, each 32x65 product split in two
	logic signed [2*E:0]  dlo_s3 [3];
	logic signed [2*E:0]  dhi_s3 [3];
	logic signed [CW-1:0] cof_s3 [N];
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int j = 0; j < 3; j++) begin
				dlo_s3[j] <= row_s2[j] * $signed({1'b0, cof_s2[3*j][E-1:0]});
				dhi_s3[j] <= row_s2[j] * $signed(cof_s2[3*j][CW-1:E]);
			end
			cof_s3 <= cof_s2;
		end
	end

	// s4: determinant sum
	logic signed [DW-1:0] det_d;
	logic signed [DW-1:0] det_s4;
	logic signed [CW-1:0] cof_s4 [N];
	always_comb begin
		det_d = '0;
		for (int j = 0; j < 3; j++) begin
			det_d = det_d + DW'(dlo_s3[j]) + (DW'(dhi_s3[j]) <<< E);
		end
	end
	always_ff @(posedge clk) begin
		if (en[3]) begin
			det_s4 <= det_d;
			cof_s4 <= cof_s3;
		end
	end

	// s5: magnitudes and signs
	m3i_pkg::lane_in_t lin_s5 [N];
	m3i_pkg::dmag_t    dmag_s5;
	logic              sing_s5;
	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int i = 0; i < N; i++) begin
				lin_s5[i].neg  <= cof_s4[i][CW-1] ^ det_s4[DW-1];
				lin_s5[i].cmag <= cof_s4[i][CW-1] ? m3i_pkg::CMW'(-cof_s4[i])
				                                  : m3i_pkg::CMW'(cof_s4[i]);
			end
			dmag_s5 <= det_s4[DW-1] ? m3i_pkg::DMW'(-det_s4) : m3i_pkg::DMW'(det_s4);
			sing_s5 <= (det_s4 == '0);
		end
	end

	// division lanes
	m3i_pkg::lane_res_t lres [N];
	for (genvar i = 0; i < N; i++) begin : g_lane
		m3i_div_lane u_lane (
			.clk    (clk),
			.en     (en[FS +: LS]),
			.din    (lin_s5[i]),
			.dmag   (dmag_s5),
			.res    (lres[i])
		);
	end

	// carry the singular flag alongside the lanes
	logic sing_sl [LS];
	always_ff @(posedge clk) begin
		if (en[FS]) begin
			sing_sl[0] <= sing_s5;
		end
		for (int k = 1; k < LS; k++) begin
			if (en[FS+k]) begin
				sing_sl[k] <= sing_sl[k-1];
			end
		end
	end

	// merge: collect clip flags, force zeros when singular
	logic [m3i_pkg::DATA_W-1:0] data_d;
	logic                       clip_any;
	always_comb begin
		data_d   = '0;
		clip_any = 1'b0;
		for (int i = 0; i < N; i++) begin
			data_d[i*E +: E] = sing_sl[LS-1] ? '0 : lres[i].elem;
			clip_any = clip_any | lres[i].clip;
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			m_tdata                          <= data_d;
			m_tuser[m3i_pkg::USER_SINGULAR]  <= sing_sl[LS-1];
			m_tuser[m3i_pkg::USER_SATURATED] <= clip_any && !sing_sl[LS-1];
		end
	end

	assign m_tvalid = vld_q[NS-1];

endmodule

FILE: rtl/m3i_checker.sv
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level checks for matrix3x3_inverse, bound to the top level.
// ----------------------------------------------------------------------------
module m3i_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [m3i_pkg::DATA_W-1:0]     m_tdata,
	input logic [m3i_pkg::USER_W-1:0]     m_tuser
);

	// hold a stalled output beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// an empty output stage means the whole pipeline can move
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[m3i_pkg::USER_SINGULAR] |-> m_tdata == '0)
		else $error("singular beat with nonzero elements");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[m3i_pkg::USER_SINGULAR] && m_tuser[m3i_pkg::USER_SATURATED]))
		else $error("singular and saturated both set");

endmodule

bind matrix3x3_inverse m3i_checker u_m3i_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
